>>> sv/spq_pkg.sv
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_BITS = 16;
  localparam int ID_BITS  = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    KIND_INSERT  = 2'd0,
    KIND_EXTRACT = 2'd1,
    KIND_CHANGE  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_PLACE
  } state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] item_id;
    logic [15:0] item_key;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] taken_id;
    logic [15:0] taken_key;
    logic [15:0] head_id;
    logic [15:0] head_key;
    logic [4:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic [ID_BITS-1:0]  id;
    logic [KEY_BITS-1:0] key;
  } entry_t;

  typedef struct packed {
    logic latch;
    logic remove_head;
    logic remove_match;
    logic place;
    logic set_empty;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       empty;
  } sts_t;

endpackage

>>> sv/spq_req_if.sv
interface spq_req_if;
  logic          valid;
  logic          ready;
  spq_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/spq_rsp_if.sv
interface spq_rsp_if;
  logic          valid;
  logic          ready;
  spq_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/sorted_priority_queue.sv
// channel  dir  transaction fields
// req_i    in   kind, item_id, item_key
// rsp_o    out  status, taken_id, taken_key, head_id, head_key, entry_count
//
// Insert, extract and empty/unknown requests go through accept and execute;
// change goes through accept, remove and place. All entries are compared and
// shifted in parallel by the register array. One request is in flight at a
// time; a new one is accepted only once the previous response is taken, at the
// earliest in the same cycle, so a stalled response holds off the request side.
// Reset clears the entry count; entry storage is not cleared.
module sorted_priority_queue (
  input logic       clk_i,
  input logic       rst_ni,
  spq_req_if.sink   req_i,
  spq_rsp_if.source rsp_o
);

  spq_pkg::cmd_t cmd;
  spq_pkg::sts_t sts;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  spq_dpath u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i.data),
    .sts_o  (sts),
    .rsp_o  (rsp_o.data)
  );

endmodule

>>> sv/spq_ctrl.sv
module spq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  input  spq_pkg::sts_t     sts_i,
  output spq_pkg::cmd_t     cmd_o
);

  spq_pkg::state_e state_q, state_d;
  logic            rsp_valid_q, rsp_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spq_pkg::S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      spq_pkg::S_IDLE: begin
        req_ready_o = !rsp_valid_q || rsp_ready_i;
        if (req_valid_i && req_ready_o) begin
          cmd_o.latch = 1'b1;
          state_d     = spq_pkg::S_EXEC;
        end
      end
      spq_pkg::S_EXEC: begin
        cmd_o.finish = 1'b1;
        state_d      = spq_pkg::S_IDLE;
        unique case (sts_i.kind)
          spq_pkg::KIND_INSERT: begin
            cmd_o.place = 1'b1;
          end
          spq_pkg::KIND_EXTRACT: begin
            cmd_o.set_empty   = sts_i.empty;
            cmd_o.remove_head = !sts_i.empty;
          end
          spq_pkg::KIND_CHANGE: begin
            if (sts_i.empty) begin
              cmd_o.set_empty = 1'b1;
            end else begin
              cmd_o.finish       = 1'b0;
              cmd_o.remove_match = 1'b1;
              state_d            = spq_pkg::S_PLACE;
            end
          end
          default: ;
        endcase
      end
      spq_pkg::S_PLACE: begin
        cmd_o.place  = 1'b1;
        cmd_o.finish = 1'b1;
        state_d      = spq_pkg::S_IDLE;
      end
      default: state_d = spq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_valid_q && rsp_ready_i) rsp_valid_d = 1'b0;
    if (cmd_o.finish) rsp_valid_d = 1'b1;
  end

  assign rsp_valid_o = rsp_valid_q;

endmodule

>>> sv/spq_dpath.sv
module spq_dpath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  spq_pkg::cmd_t cmd_i,
  input  spq_pkg::req_t req_i,
  output spq_pkg::sts_t sts_o,
  output spq_pkg::rsp_t rsp_o
);

  localparam int CapW = spq_pkg::CNT_W;

  spq_pkg::entry_t ent_q [spq_pkg::CAPACITY];
  spq_pkg::entry_t ent_d [spq_pkg::CAPACITY];
  logic [CapW-1:0] cnt_q, cnt_d;

  logic [1:0]                   kind_q;
  logic [spq_pkg::ID_BITS-1:0]  id_q;
  logic [spq_pkg::KEY_BITS-1:0] key_q;
  spq_pkg::status_e             status_q, status_d;
  spq_pkg::entry_t              taken_q, taken_d;
  spq_pkg::rsp_t                rsp_q;

  logic [spq_pkg::CAPACITY-1:0] live, match, shift_up, gt;
  logic                         any_match, full;

  always_comb begin
    logic run;
    run = 1'b0;
    for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
      live[i]     = CapW'(i) < cnt_q;
      match[i]    = live[i] && (ent_q[i].id == id_q);
      run         = run || match[i];
      shift_up[i] = run;
      gt[i]       = live[i] && (ent_q[i].key > key_q);
    end
    any_match = run;
  end

  assign full = (cnt_q == CapW'(spq_pkg::CAPACITY));

  always_comb begin
    ent_d    = ent_q;
    cnt_d    = cnt_q;
    status_d = status_q;
    taken_d  = taken_q;
    if (cmd_i.latch) begin
      status_d = spq_pkg::ST_OK;
      taken_d  = '0;
    end
    if (cmd_i.set_empty) status_d = spq_pkg::ST_EMPTY;
    if (cmd_i.remove_head || cmd_i.remove_match) begin
      for (int i = 0; i < spq_pkg::CAPACITY - 1; i++) begin
        if (cmd_i.remove_head || shift_up[i]) ent_d[i] = ent_q[i+1];
      end
      if (cmd_i.remove_head) begin
        taken_d = ent_q[0];
        cnt_d   = cnt_q - CapW'(1);
      end else if (any_match) begin
        cnt_d = cnt_q - CapW'(1);
      end
    end else if (cmd_i.place) begin
      if (full) begin
        status_d = spq_pkg::ST_FULL;
      end else begin
        if (!gt[0]) begin
          ent_d[0] = '{id: id_q, key: key_q};
        end
        for (int i = 1; i < spq_pkg::CAPACITY; i++) begin
          if (!gt[i]) begin
            if (gt[i-1]) begin
              ent_d[i] = '{id: id_q, key: key_q};
            end else begin
              ent_d[i] = ent_q[i-1];
            end
          end
        end
        cnt_d = cnt_q + CapW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q    <= ent_d;
    status_q <= status_d;
    taken_q  <= taken_d;
    if (cmd_i.latch) begin
      kind_q <= req_i.kind;
      id_q   <= spq_pkg::ID_BITS'(req_i.item_id);
      key_q  <= spq_pkg::KEY_BITS'(req_i.item_key);
    end
    if (cmd_i.finish) begin
      rsp_q.status      <= status_d;
      rsp_q.taken_id    <= 16'(taken_d.id);
      rsp_q.taken_key   <= 16'(taken_d.key);
      rsp_q.head_id     <= (cnt_d == '0) ? 16'd0 : 16'(ent_d[0].id);
      rsp_q.head_key    <= (cnt_d == '0) ? 16'd0 : 16'(ent_d[0].key);
      rsp_q.entry_count <= 5'(cnt_d);
    end
  end

  assign sts_o.kind  = kind_q;
  assign sts_o.empty = (cnt_q == '0);
  assign rsp_o       = rsp_q;

endmodule

>>> tb/spq_checker.sv
module spq_checker
  import spq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  input  logic req_ready_i,
  input  req_t req_data_i,
  input  logic rsp_valid_i,
  input  logic rsp_ready_i,
  input  rsp_t rsp_data_i,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  bit [ID_BITS-1:0]  q_ids  [CAPACITY];
  bit [KEY_BITS-1:0] q_keys [CAPACITY];
  int                q_cnt;
  rsp_t              expected_rsps [$];
  rsp_t              exp_rsp;
  int                mismatches;
  bit                bad;

  function automatic bit place_entry(bit [ID_BITS-1:0] id, bit [KEY_BITS-1:0] key);
    int pos;
    if (q_cnt >= CAPACITY) return 1'b0;
    pos = 0;
    while (pos < q_cnt && q_keys[pos] > key) pos++;
    for (int i = q_cnt; i > pos; i--) begin
      q_ids[i]  = q_ids[i-1];
      q_keys[i] = q_keys[i-1];
    end
    q_ids[pos]  = id;
    q_keys[pos] = key;
    q_cnt++;
    return 1'b1;
  endfunction

  function automatic void remove_entry(int pos);
    if (pos >= q_cnt) return;
    for (int i = pos; i + 1 < q_cnt; i++) begin
      q_ids[i]  = q_ids[i+1];
      q_keys[i] = q_keys[i+1];
    end
    q_cnt--;
  endfunction

  function automatic rsp_t predict_rsp(req_t r);
    rsp_t              e;
    bit [ID_BITS-1:0]  id;
    bit [KEY_BITS-1:0] key;
    e   = '0;
    id  = r.item_id;
    key = r.item_key;
    case (r.kind)
      KIND_INSERT: begin
        if (!place_entry(id, key)) e.status = ST_FULL;
      end
      KIND_EXTRACT: begin
        if (q_cnt == 0) begin
          e.status = ST_EMPTY;
        end else begin
          e.taken_id  = q_ids[0];
          e.taken_key = q_keys[0];
          remove_entry(0);
        end
      end
      KIND_CHANGE: begin
        if (q_cnt == 0) begin
          e.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < q_cnt; i++) begin
            if (q_ids[i] == id) begin
              remove_entry(i);
              break;
            end
          end
          if (!place_entry(id, key)) e.status = ST_FULL;
        end
      end
      default: ;
    endcase
    if (q_cnt > 0) begin
      e.head_id  = q_ids[0];
      e.head_key = q_keys[0];
    end
    e.entry_count = 5'(q_cnt);
    return e;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_cnt      = 0;
      mismatches = 0;
      expected_rsps.delete();
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_rsps.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected rsp transaction: status=%0d taken=%0h/%0h head=%0h/%0h cnt=%0d",
                     rsp_data_i.status, rsp_data_i.taken_id, rsp_data_i.taken_key,
                     rsp_data_i.head_id, rsp_data_i.head_key, rsp_data_i.entry_count);
          mismatches++;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          bad = (exp_rsp.status      !== rsp_data_i.status)
             || (exp_rsp.taken_id    !== rsp_data_i.taken_id)
             || (exp_rsp.taken_key   !== rsp_data_i.taken_key)
             || (exp_rsp.head_id     !== rsp_data_i.head_id)
             || (exp_rsp.head_key    !== rsp_data_i.head_key)
             || (exp_rsp.entry_count !== rsp_data_i.entry_count);
          if (bad) begin
            if (mismatches < 10) begin
              $display("rsp mismatch exp: status=%0d taken=%0h/%0h head=%0h/%0h cnt=%0d",
                       exp_rsp.status, exp_rsp.taken_id, exp_rsp.taken_key,
                       exp_rsp.head_id, exp_rsp.head_key, exp_rsp.entry_count);
              $display("             got: status=%0d taken=%0h/%0h head=%0h/%0h cnt=%0d",
                       rsp_data_i.status, rsp_data_i.taken_id, rsp_data_i.taken_key,
                       rsp_data_i.head_id, rsp_data_i.head_key, rsp_data_i.entry_count);
            end
            mismatches++;
          end
        end
      end
      if (req_valid_i && req_ready_i) expected_rsps.push_back(predict_rsp(req_data_i));
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_rsps.size();
  end

endmodule

>>> tb/sorted_priority_queue_tb.sv
module sorted_priority_queue_tb;
  import spq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int         WATCHDOG    = 2000;
  localparam int         PHASE_ITEMS = 100;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int idle_pct    = 0;
  int stall_pct   = 0;
  int n_sent      = 0;
  int n_rcvd      = 0;
  int idle_cycles = 0;
  int fail_count;
  int pending;
  bit filling;

  spq_req_if req_if ();
  spq_rsp_if rsp_if ();

  sorted_priority_queue i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  spq_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_valid_i  (req_if.valid),
    .req_ready_i  (req_if.ready),
    .req_data_i   (req_if.data),
    .rsp_valid_i  (rsp_if.valid),
    .rsp_ready_i  (rsp_if.ready),
    .rsp_data_i   (rsp_if.data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (req_if.valid && req_if.ready) n_sent <= n_sent + 1;
    if (rsp_if.valid && rsp_if.ready) n_rcvd <= n_rcvd + 1;
  end

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic req_t mk_req(logic [1:0] kind, logic [15:0] id, logic [15:0] key);
    req_t r;
    r.kind     = kind;
    r.item_id  = id;
    r.item_key = key;
    return r;
  endfunction

  function automatic req_t rand_req(bit fill);
    int   sel;
    req_t r;
    sel = $urandom_range(99);
    if (sel < 2) begin
      r.kind = KIND_UNUSED;
    end else if (sel < (fill ? 62 : 22)) begin
      r.kind = KIND_INSERT;
    end else if (sel < (fill ? 80 : 77)) begin
      r.kind = KIND_EXTRACT;
    end else begin
      r.kind = KIND_CHANGE;
    end
    // small id pool so that change mostly hits stored entries
    r.item_id = ($urandom_range(99) < 80) ? 16'($urandom_range(23)) : 16'($urandom);
    sel = $urandom_range(99);
    if (sel < 40) begin
      r.item_key = 16'($urandom_range(7));
    end else if (sel < 45) begin
      r.item_key = 16'h0000;
    end else if (sel < 50) begin
      r.item_key = 16'hFFFF;
    end else begin
      r.item_key = 16'($urandom);
    end
    return r;
  endfunction

  task automatic send_req(input req_t r);
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  task automatic wait_all_rsps();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (n_rcvd != n_sent);
  endtask

  initial begin
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue cases
    send_req(mk_req(KIND_EXTRACT, 16'h0011, 16'h0022));
    send_req(mk_req(KIND_CHANGE,  16'h0011, 16'h0022));
    send_req(mk_req(KIND_UNUSED,  16'hFFFF, 16'hFFFF));
    send_req(mk_req(KIND_INSERT,  16'h0000, 16'h0000));
    send_req(mk_req(KIND_INSERT,  16'hFFFF, 16'hFFFF));
    // tie with head goes in front
    send_req(mk_req(KIND_INSERT,  16'h0005, 16'hFFFF));
    send_req(mk_req(KIND_INSERT,  16'h0005, 16'h0064));
    // duplicate id: only the one nearest the head moves
    send_req(mk_req(KIND_CHANGE,  16'h0005, 16'h0007));
    send_req(mk_req(KIND_CHANGE,  16'h1234, 16'h00C8));
    send_req(mk_req(KIND_UNUSED,  16'h0000, 16'h0000));
    send_req(mk_req(KIND_EXTRACT, 16'h0000, 16'h0000));
    for (int i = 0; i < 12; i++)
      send_req(mk_req(KIND_INSERT, 16'h0100 + 16'(i), i[0] ? 16'hAAAA : 16'h5555));
    send_req(mk_req(KIND_INSERT,  16'h7777, 16'h8000));
    send_req(mk_req(KIND_CHANGE,  16'hBEEF, 16'h0001));
    send_req(mk_req(KIND_CHANGE,  16'h0100, 16'h0001));
    wait_all_rsps();

    filling = 1'b0;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1:       begin idle_pct = 52; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 52; end
        3:       begin idle_pct = 15; stall_pct = 15; end
        default: begin idle_pct = 0;  stall_pct = 0;  end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 30 == 0) filling = ~filling;
        send_req(rand_req(filling));
      end
      if (ph == 2) wait_all_rsps();
    end

    wait_all_rsps();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/spq_pkg.sv
sv/spq_req_if.sv
sv/spq_rsp_if.sv
sv/spq_ctrl.sv
sv/spq_dpath.sv
sv/sorted_priority_queue.sv
tb/spq_checker.sv
tb/sorted_priority_queue_tb.sv
